### design/vks_pkg.sv
// Shared types, codes and velocity-curve constants for the velocity key scanner.
package vks_pkg;

   // Input item: one contact sample or one end-of-frame marker.
   typedef struct packed {
      logic        cmd;
      logic [5:0]  key_index;
      logic        contact_sel;
      logic        contact_level;
      logic [31:0] now_ms;
      logic        retrigger_on;
      logic        midi_enable;
      logic        hold_on;
   } req_type;

   // Result item: one per input item.
   typedef struct packed {
      logic [1:0]  event_kind;
      logic [6:0]  note_number;
      logic [6:0]  velocity;
      logic        announce;
      logic        gate_low;
      logic [31:0] retrigger_deadline;
      logic [48:0] held_mask;
   } rsp_type;

   // Input commands
   localparam logic CMD_SAMPLE    = 1'b0;
   localparam logic CMD_FRAME_END = 1'b1;

   // Contact select
   localparam logic CONTACT_FIRST  = 1'b0;
   localparam logic CONTACT_SECOND = 1'b1;

   // Event kinds
   localparam logic [1:0] EV_NONE      = 2'd0;
   localparam logic [1:0] EV_KEY_DOWN  = 2'd1;
   localparam logic [1:0] EV_KEY_UP    = 2'd2;
   localparam logic [1:0] EV_FRAME_END = 2'd3;

   // Register index, taken from paddr[2]
   localparam logic REG_LOWEST_NOTE    = 1'b0;
   localparam logic REG_RETRIGGER_DLY  = 1'b1;

   localparam logic [6:0] LOWEST_NOTE_RESET   = 7'd36;
   localparam logic [7:0] RETRIGGER_DLY_RESET = 8'd10;

   // Velocity curve, slow branch: (64*a + 1245) / 35 via reciprocal multiply.
   localparam logic [9:0]  ATTACK_MAX    = 10'd1023;
   localparam logic [16:0] VEL_OFFSET    = 17'd1245;
   localparam logic [15:0] VEL_RECIP     = 16'd59919;
   localparam int          VEL_SHIFT     = 21;
   localparam logic [11:0] VEL_TOP       = 12'd127;

   // Velocity curve, fast branch: 127 - (63*a - 126) / 13, clamped, a in 0..15.
   function automatic logic [6:0] fast_velocity(input logic [3:0] attack);
      logic [6:0] v;
      case (attack)
         4'd0:    v = 7'd127;
         4'd1:    v = 7'd127;
         4'd2:    v = 7'd127;
         4'd3:    v = 7'd123;
         4'd4:    v = 7'd118;
         4'd5:    v = 7'd113;
         4'd6:    v = 7'd108;
         4'd7:    v = 7'd103;
         4'd8:    v = 7'd98;
         4'd9:    v = 7'd94;
         4'd10:   v = 7'd89;
         4'd11:   v = 7'd84;
         4'd12:   v = 7'd79;
         4'd13:   v = 7'd74;
         4'd14:   v = 7'd69;
         4'd15:   v = 7'd64;
         default: v = 7'd127;
      endcase
      return v;
   endfunction

endpackage

### design/velocity_key_scanner.sv
// Velocity key scanner: contact edge detection, velocity curve and held-key mask.
// Stage one registers an accepted item; its result is then registered for rsp_valid.
// Throughput: one item per cycle unless stalled; the press-time read is issued at acceptance
// and forwarded from a same-cycle write, so back-to-back samples of one key need no bubble.
// Reset: synchronous, clears contact levels, press times (valid bits), masks, deadline
// and pipeline valids, and loads lowest_note 36 and retrigger_delay_ms 10.
module velocity_key_scanner
   import vks_pkg::*;
#(
   parameter int NUM_KEYBOARD_KEYS = 49
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int KEY_W = $clog2(NUM_KEYBOARD_KEYS);

   // Configuration
   logic [6:0] lowest_note_ff;
   logic [7:0] retrig_dly_ff;
   logic       csr_write;

   // Pipeline
   logic        s1_valid_ff;
   req_type     s1_item_ff;
   logic [31:0] start_rd_ff;
   logic        out_valid_ff;
   rsp_type     out_item_ff;
   rsp_type     out_item_in;
   logic        req_accept;
   logic        s1_adv;

   // Key state
   logic [NUM_KEYBOARD_KEYS-1:0] first_ff,  first_in;
   logic [NUM_KEYBOARD_KEYS-1:0] second_ff, second_in;
   logic [NUM_KEYBOARD_KEYS-1:0] start_vld_ff, start_vld_in;
   logic [NUM_KEYBOARD_KEYS-1:0] pressed_ff, pressed_in;
   logic [NUM_KEYBOARD_KEYS-1:0] held_ff, held_in;
   logic                         new_press_ff, new_press_in;
   logic [31:0]                  deadline_ff, deadline_in;
   logic [31:0]                  press_mem [NUM_KEYBOARD_KEYS];

   // Processing of the item in stage one
   logic                         in_range;
   logic [KEY_W-1:0]             key_lo;
   logic [KEY_W-1:0]             rd_addr;
   logic [NUM_KEYBOARD_KEYS-1:0] key_bit;
   logic                         mem_we;
   logic [31:0]                  start_ms;
   logic [31:0]                  elapsed;
   logic [9:0]                   attack;
   logic [16:0]                  numer;
   logic [32:0]                  product;
   logic [11:0]                  quot;
   logic [6:0]                   slow_vel;
   logic [6:0]                   velocity;
   logic [63:0]                  held_wide;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         REG_LOWEST_NOTE:   prdata = {25'd0, lowest_note_ff};
         REG_RETRIGGER_DLY: prdata = {24'd0, retrig_dly_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // Handshake: stage one moves on whenever the result register is free or drains.
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_payload = out_item_ff;

   assign key_lo   = s1_item_ff.key_index[KEY_W-1:0];
   assign rd_addr  = req_payload.key_index[KEY_W-1:0];
   assign in_range = {1'b0, s1_item_ff.key_index} < 7'(NUM_KEYBOARD_KEYS);
   assign key_bit  = {{(NUM_KEYBOARD_KEYS-1){1'b0}}, 1'b1} << key_lo;

   // Record press start on a first-contact rising edge.
   assign mem_we = s1_adv && s1_item_ff.cmd == CMD_SAMPLE && in_range
                   && s1_item_ff.contact_sel == CONTACT_FIRST
                   && s1_item_ff.contact_level && !first_ff[key_lo];

   // Velocity curve
   assign start_ms = start_vld_ff[key_lo] ? start_rd_ff : 32'd0;
   assign elapsed  = s1_item_ff.now_ms - start_ms;
   assign attack   = (|elapsed[31:10]) ? ATTACK_MAX : elapsed[9:0];
   assign numer    = {1'b0, attack, 6'd0} + VEL_OFFSET;
   assign product  = numer * VEL_RECIP;
   assign quot     = product[VEL_SHIFT+11:VEL_SHIFT];
   assign slow_vel = (quot > VEL_TOP) ? 7'd0 : 7'(VEL_TOP - quot);
   assign velocity = (attack > 10'd15) ? slow_vel : fast_velocity(attack[3:0]);

   always_comb begin
      first_in     = first_ff;
      second_in    = second_ff;
      start_vld_in = start_vld_ff;
      pressed_in   = pressed_ff;
      held_in      = held_ff;
      new_press_in = new_press_ff;
      deadline_in  = deadline_ff;

      out_item_in                    = '0;
      out_item_in.event_kind         = EV_NONE;

      if (s1_item_ff.cmd == CMD_FRAME_END) begin
         if (!s1_item_ff.hold_on || new_press_ff) begin
            held_in = pressed_ff;
         end
         new_press_in           = 1'b0;
         out_item_in.event_kind = EV_FRAME_END;
      end else if (in_range) begin
         if (s1_item_ff.contact_sel == CONTACT_FIRST) begin
            first_in[key_lo] = s1_item_ff.contact_level;
            if (mem_we) begin
               start_vld_in[key_lo] = 1'b1;
            end
         end else begin
            second_in[key_lo] = s1_item_ff.contact_level;
            if (s1_item_ff.contact_level && !second_ff[key_lo]) begin
               pressed_in   = pressed_ff | key_bit;
               new_press_in = 1'b1;
               deadline_in  = s1_item_ff.retrigger_on
                              ? s1_item_ff.now_ms + {24'd0, retrig_dly_ff} : 32'd0;
               out_item_in.event_kind  = EV_KEY_DOWN;
               out_item_in.note_number = lowest_note_ff + {1'b0, s1_item_ff.key_index};
               out_item_in.velocity    = velocity;
               out_item_in.announce    = s1_item_ff.midi_enable;
               out_item_in.gate_low    = s1_item_ff.retrigger_on;
            end else if (!s1_item_ff.contact_level && second_ff[key_lo]) begin
               pressed_in = pressed_ff & ~key_bit;
               out_item_in.event_kind  = EV_KEY_UP;
               out_item_in.note_number = lowest_note_ff + {1'b0, s1_item_ff.key_index};
               out_item_in.announce    = s1_item_ff.midi_enable;
            end
         end
      end

      held_wide = 64'(held_in);
      out_item_in.retrigger_deadline = deadline_in;
      out_item_in.held_mask          = held_wide[48:0];
   end

   // Press-time memory; forward a same-cycle write to the read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         press_mem[key_lo] <= s1_item_ff.now_ms;
      end
      if (req_accept) begin
         if (mem_we && key_lo == rd_addr) begin
            start_rd_ff <= s1_item_ff.now_ms;
         end else begin
            start_rd_ff <= press_mem[rd_addr];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_payload;
      end
      if (s1_adv) begin
         out_item_ff <= out_item_in;
      end
   end

   // Control and key state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         first_ff       <= '0;
         second_ff      <= '0;
         start_vld_ff   <= '0;
         pressed_ff     <= '0;
         held_ff        <= '0;
         new_press_ff   <= 1'b0;
         deadline_ff    <= 32'd0;
         lowest_note_ff <= LOWEST_NOTE_RESET;
         retrig_dly_ff  <= RETRIGGER_DLY_RESET;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end

         if (s1_adv) begin
            first_ff     <= first_in;
            second_ff    <= second_in;
            start_vld_ff <= start_vld_in;
            pressed_ff   <= pressed_in;
            held_ff      <= held_in;
            new_press_ff <= new_press_in;
            deadline_ff  <= deadline_in;
         end

         if (csr_write) begin
            case (paddr[2])
               REG_LOWEST_NOTE:   lowest_note_ff <= pwdata[6:0];
               REG_RETRIGGER_DLY: retrig_dly_ff  <= pwdata[7:0];
               default:           lowest_note_ff <= lowest_note_ff;
            endcase
         end
      end
   end

endmodule

### bench/tb_top.sv
// Self-checking testbench for the velocity key scanner: directed and random contact traffic.
module tb_top
   import vks_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_COUNT    = 49;
   localparam int LONG_HOLD    = 60;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int REQ_W        = $bits(req_type);

   typedef enum logic [1:0] {
      GESTURE_IDLE, GESTURE_ARMED, GESTURE_DOWN, GESTURE_RELEASED
   } gesture_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // stimulus side
   req_type     pending_items[$];
   gesture_type gesture[KEY_COUNT];
   bit [31:0]   stim_ms;
   int unsigned focus_key;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned hold_cycles;
   logic        hold_start = 1'b0;

   // scanner prediction state
   bit                  first_closed[KEY_COUNT];
   bit                  second_closed[KEY_COUNT];
   bit [31:0]           press_time[KEY_COUNT];
   bit [KEY_COUNT-1:0]  pressed_keys;
   bit [KEY_COUNT-1:0]  held_keys;
   bit                  fresh_press;
   bit [31:0]           retrig_deadline;
   bit [6:0]            base_note = LOWEST_NOTE_RESET;
   bit [7:0]            retrig_delay = RETRIGGER_DLY_RESET;
   rsp_type             expected_events[$];
   rsp_type             oldest_event;
   int unsigned         mismatch_count = 0;

   velocity_key_scanner #(.NUM_KEYBOARD_KEYS(KEY_COUNT)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Piecewise-linear attack-time curve, truncating division, clamped to 0..127.
   function automatic bit [6:0] attack_velocity(input bit [31:0] elapsed);
      int a;
      int v;
      a = (elapsed > 1023) ? 1023 : int'(elapsed);
      if (a > 15)
         v = (64 * a + 1245) / 35;
      else
         v = (63 * a - 126) / 13;
      v = 127 - v;
      if (v > 127)
         v = 127;
      else if (v < 0)
         v = 0;
      return v[6:0];
   endfunction

   task automatic predict_item(input req_type item);
      rsp_type ev;
      int      k;
      ev = '0;
      k = int'(item.key_index);
      if (item.cmd == CMD_FRAME_END) begin
         if (!item.hold_on || fresh_press)
            held_keys = pressed_keys;
         fresh_press = 1'b0;
         ev.event_kind = EV_FRAME_END;
      end else if (k < KEY_COUNT) begin
         if (item.contact_sel == CONTACT_FIRST) begin
            if (item.contact_level && !first_closed[k])
               press_time[k] = item.now_ms;
            first_closed[k] = item.contact_level;
         end else begin
            if (item.contact_level && !second_closed[k]) begin
               pressed_keys[k] = 1'b1;
               fresh_press = 1'b1;
               retrig_deadline = item.retrigger_on ? item.now_ms + retrig_delay : 32'd0;
               ev.event_kind = EV_KEY_DOWN;
               ev.note_number = 7'(base_note + k);
               ev.velocity = attack_velocity(item.now_ms - press_time[k]);
               ev.announce = item.midi_enable;
               ev.gate_low = item.retrigger_on;
            end else if (!item.contact_level && second_closed[k]) begin
               pressed_keys[k] = 1'b0;
               ev.event_kind = EV_KEY_UP;
               ev.note_number = 7'(base_note + k);
               ev.announce = item.midi_enable;
            end
            second_closed[k] = item.contact_level;
         end
      end
      ev.retrigger_deadline = retrig_deadline;
      ev.held_mask = held_keys;
      expected_events.push_back(ev);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%t %s: expected %0h, actual %0h", $realtime, name, want, got);
      end
   endtask

   // Sender: predict each transfer as it is accepted, then offer the next item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_item(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
               req_valid <= 1'b0;
            end else if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
               gap_left <= $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
   always @(posedge clock) begin
      if (reset)
         hold_cycles <= 0;
      else if (hold_start)
         hold_cycles <= LONG_HOLD;
      else if (hold_cycles != 0)
         hold_cycles <= hold_cycles - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (hold_cycles != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%t result with nothing expected: %p", $realtime, rsp_payload);
         end else begin
            oldest_event = expected_events.pop_front();
            compare_field("event_kind", 64'(oldest_event.event_kind),
                          64'(rsp_payload.event_kind));
            compare_field("note_number", 64'(oldest_event.note_number),
                          64'(rsp_payload.note_number));
            compare_field("velocity", 64'(oldest_event.velocity),
                          64'(rsp_payload.velocity));
            compare_field("announce", 64'(oldest_event.announce),
                          64'(rsp_payload.announce));
            compare_field("gate_low", 64'(oldest_event.gate_low),
                          64'(rsp_payload.gate_low));
            compare_field("retrigger_deadline", 64'(oldest_event.retrigger_deadline),
                          64'(rsp_payload.retrigger_deadline));
            compare_field("held_mask", 64'(oldest_event.held_mask),
                          64'(rsp_payload.held_mask));
         end
      end
   end

   function automatic req_type make_sample(input int unsigned key, input logic sel,
                                           input logic level, input logic [31:0] ms,
                                           input logic retrig, input logic midi);
      req_type item;
      item.cmd = CMD_SAMPLE;
      item.key_index = 6'(key);
      item.contact_sel = sel;
      item.contact_level = level;
      item.now_ms = ms;
      item.retrigger_on = retrig;
      item.midi_enable = midi;
      item.hold_on = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // Everything but hold is ignored on a frame end, so fill the rest with noise.
   function automatic req_type make_frame_end(input logic hold);
      req_type item;
      item = REQ_W'({$urandom, $urandom});
      item.cmd = CMD_FRAME_END;
      item.hold_on = hold;
      return item;
   endfunction

   task automatic queue_directed_items();
      pending_items.push_back(make_frame_end(1'b0));
      // zero attack time, retrigger deadline from the reset delay
      pending_items.push_back(make_sample(0, CONTACT_FIRST, 1'b1, 32'd100, 1'b1, 1'b1));
      pending_items.push_back(make_sample(0, CONTACT_SECOND, 1'b1, 32'd100, 1'b1, 1'b1));
      // top key, first step of the slow branch, no retrigger
      pending_items.push_back(make_sample(48, CONTACT_FIRST, 1'b1, 32'd1000, 1'b0, 1'b1));
      pending_items.push_back(make_sample(48, CONTACT_SECOND, 1'b1, 32'd1016, 1'b0, 1'b1));
      // last step of the fast branch
      pending_items.push_back(make_sample(1, CONTACT_FIRST, 1'b1, 32'd2000, 1'b1, 1'b0));
      pending_items.push_back(make_sample(1, CONTACT_SECOND, 1'b1, 32'd2015, 1'b1, 1'b0));
      // attack across the time wrap, saturated
      pending_items.push_back(make_sample(2, CONTACT_FIRST, 1'b1, 32'hFFFF_FFF0, 1'b1, 1'b1));
      pending_items.push_back(make_sample(2, CONTACT_SECOND, 1'b1, 32'h0000_0400, 1'b1, 1'b1));
      // deadline wraps past the top of the time range
      pending_items.push_back(make_sample(3, CONTACT_FIRST, 1'b1, 32'hFFFF_FC01, 1'b0, 1'b0));
      pending_items.push_back(make_sample(3, CONTACT_SECOND, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
      pending_items.push_back(make_frame_end(1'b1));
      pending_items.push_back(make_sample(0, CONTACT_SECOND, 1'b0, 32'd2100, 1'b0, 1'b1));
      // hold with no new press keeps the old mask
      pending_items.push_back(make_frame_end(1'b1));
      pending_items.push_back(make_sample(0, CONTACT_FIRST, 1'b0, 32'd2101, 1'b0, 1'b0));
      pending_items.push_back(make_sample(48, CONTACT_SECOND, 1'b1, 32'd2102, 1'b1, 1'b1));
      pending_items.push_back(make_sample(49, CONTACT_SECOND, 1'b1, 32'd2103, 1'b1, 1'b1));
      pending_items.push_back(make_sample(63, CONTACT_FIRST, 1'b1, 32'd2104, 1'b1, 1'b1));
      // second contact with no first-contact edge ever seen
      pending_items.push_back(make_sample(5, CONTACT_SECOND, 1'b1, 32'd5, 1'b1, 1'b1));
      // negative quotient on the fast branch
      pending_items.push_back(make_sample(6, CONTACT_FIRST, 1'b1, 32'd3000, 1'b0, 1'b1));
      pending_items.push_back(make_sample(6, CONTACT_SECOND, 1'b1, 32'd3001, 1'b0, 1'b1));
      pending_items.push_back(make_frame_end(1'b0));
      pending_items.push_back(make_sample(5, CONTACT_SECOND, 1'b0, 32'd3002, 1'b1, 1'b0));
      pending_items.push_back(make_sample(48, CONTACT_SECOND, 1'b0, 32'd3003, 1'b0, 1'b1));
      pending_items.push_back(make_frame_end(1'b0));
   endtask

   // Mostly complete key gestures on a few neighboring keys, some noise and frame ends.
   task automatic queue_random_items(input int unsigned count);
      req_type     item;
      int unsigned k;
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            item = make_frame_end(1'($urandom_range(0, 1)));
         end else if (pick < 20) begin
            item = REQ_W'({$urandom, $urandom});
            item.cmd = CMD_SAMPLE;
         end else begin
            if ($urandom_range(0, 19) == 0)
               focus_key = $urandom_range(0, KEY_COUNT - 1);
            k = (focus_key + $urandom_range(0, 2)) % KEY_COUNT;
            case ($urandom_range(0, 31))
               0:       stim_ms = $urandom;
               1:       stim_ms = 32'hFFFF_FFFF - $urandom_range(0, 24);
               2, 3, 4: stim_ms += $urandom_range(16, 1100);
               default: stim_ms += $urandom_range(0, 8);
            endcase
            case (gesture[k])
               GESTURE_IDLE: begin
                  item = make_sample(k, CONTACT_FIRST, 1'b1, stim_ms,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  gesture[k] = GESTURE_ARMED;
               end
               GESTURE_ARMED: begin
                  item = make_sample(k, CONTACT_SECOND, 1'b1, stim_ms,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  gesture[k] = GESTURE_DOWN;
               end
               GESTURE_DOWN: begin
                  item = make_sample(k, CONTACT_SECOND, 1'b0, stim_ms,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  gesture[k] = GESTURE_RELEASED;
               end
               default: begin
                  item = make_sample(k, CONTACT_FIRST, 1'b0, stim_ms,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  gesture[k] = GESTURE_IDLE;
               end
            endcase
         end
         pending_items.push_back(item);
      end
   endtask

   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic reg_index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_index == REG_LOWEST_NOTE)
         base_note = value[6:0];
      else
         retrig_delay = value[7:0];
   endtask

   task automatic run_phase(input int unsigned count, input int unsigned send_pct,
                            input int unsigned recv_pct, input bit long_hold);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      queue_random_items(count);
      if (long_hold) begin
         @(posedge clock);
         hold_start <= 1'b1;
         @(posedge clock);
         hold_start <= 1'b0;
      end
      wait_until_drained();
   endtask

   initial begin
      for (int k = 0; k < KEY_COUNT; k++)
         gesture[k] = GESTURE_IDLE;
      stim_ms = $urandom;
      focus_key = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 25;
      recv_idle_pct = 25;
      queue_directed_items();
      wait_until_drained();

      write_register(REG_LOWEST_NOTE, 32'd79);
      write_register(REG_RETRIGGER_DLY, 32'd255);
      run_phase(300, 30, 30, 1'b0);

      write_register(REG_LOWEST_NOTE, 32'd0);
      write_register(REG_RETRIGGER_DLY, 32'd0);
      run_phase(300, 20, 10, 1'b1);

      write_register(REG_LOWEST_NOTE, $urandom_range(0, 79));
      write_register(REG_RETRIGGER_DLY, $urandom_range(0, 255));
      run_phase(350, 0, 0, 1'b0);

      write_register(REG_LOWEST_NOTE, 32'd0);
      write_register(REG_RETRIGGER_DLY, 32'd255);
      run_phase(350, 45, 45, 1'b0);

      // closing stretch runs at full rate on both sides
      write_register(REG_LOWEST_NOTE, $urandom_range(0, 79));
      write_register(REG_RETRIGGER_DLY, $urandom_range(0, 255));
      run_phase(400, 0, 0, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_events.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### velocity_key_scanner.f
design/vks_pkg.sv
design/velocity_key_scanner.sv
bench/tb_top.sv
